// ===== hw/rtl/rv32_subset_execute_unit_macros.svh =====
// assertion macros for the rv32 subset execute unit checker
// no dependencies
`ifndef RV32_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define RV32_SUBSET_EXECUTE_UNIT_MACROS_SVH
// implication checked on every clock unless reset
`define RV_ASSERT_IMP(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) cond) else $error("%m failed");
// condition that must never hold outside reset
`define RV_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`endif

// ===== hw/rtl/rvx_pkg.sv =====
// shared types and constants for the rv32 subset execute unit
// no dependencies
`timescale 1ns / 1ps
package rvx_pkg;
  localparam int unsigned MemoryBytes = 65536;
  localparam int unsigned MemAw = $clog2(MemoryBytes);

  localparam logic [6:0] OP_R = 7'h33;
  localparam logic [6:0] OP_I = 7'h13;
  localparam logic [6:0] OP_LOAD = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI = 7'h37;
  localparam logic [6:0] OP_JAL = 7'h6f;
  localparam logic [6:0] OP_ECALL = 7'h73;
  localparam logic [6:0] F7_ALT = 7'h20;
  localparam logic [6:0] F7_MUL = 7'h01;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_PRINT = 3'd1;
  localparam logic [2:0] ST_EXIT = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_BAD_ECALL = 3'd4;
  localparam logic [2:0] ST_BAD_MEM = 3'd5;
  localparam logic [2:0] ST_HALTED = 3'd6;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REG, S_EXEC, S_DIV, S_MUL, S_MEM, S_LOAD, S_STORE, S_OUT
  } state_t;
endpackage

// ===== hw/rtl/rv32_subset_execute_unit.sv =====
// rv32 subset execute unit: register file, pc and byte data store
// depends on rvx_pkg
`timescale 1ns / 1ps
// usage:
//   s_axis carries one instruction word per beat, m_axis one result per beat.
//   s_axis_tready is high only while the unit is idle; one instruction at a time.
//   an instruction passes through register read (a, b, a0, a1), execute and
//   result states; mul/mulh add a multiply state, div/rem a divide state with
//   one quotient bit a cycle, loads and stores a range check and a byte loop.
//   the rate is set by the register file's single read port and byte-wide data memory.
//   after reset a clearing pass writes zero to each of the 65536 data bytes and
//   the 32 registers, one entry a cycle, during which no instruction is taken.
//   the result is held in m_axis until taken; a stalled receiver holds the
//   unit, the next instruction is taken after the result beat completes.
//   halting statuses freeze the state until reset, later beats report halted.
module rv32_subset_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // instruction
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // next_pc, status, print_value, zero fill
);
  localparam int unsigned Aw = rvx_pkg::MemAw;

  rvx_pkg::state_t state, state_next;
  logic [31:0] rf [32];
  logic [7:0]  dmem [rvx_pkg::MemoryBytes];
  logic [31:0] ins, pc, a, b, a10, res, npc, pv, addr;
  logic [2:0]  st;
  logic        halted, wr_en;
  logic [Aw:0] clr;
  logic [1:0]  bcnt;
  logic [1:0]  rcnt;
  logic [7:0]  mem_q;
  logic signed [63:0] mprod;
  logic [31:0] quo, rem_r, dvs;
  logic [5:0]  dcnt;

  // decode fields
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [4:0] rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_j;
  assign op = ins[6:0];
  assign f3 = ins[14:12];
  assign f7 = ins[31:25];
  assign rd = ins[11:7];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};

  logic [1:0] msize;
  logic [32:0] mend;
  assign msize = f3[1:0];
  assign mend = {1'b0, addr} + ((33'd1 << msize) );

  // register file read port, sequenced a, b, a0, a1
  logic [4:0] raddr;
  logic [31:0] rq;
  always_comb begin
    unique case (rcnt)
      2'd0: raddr = ins[19:15];
      2'd1: raddr = ins[24:20];
      2'd2: raddr = 5'd10;
      default: raddr = 5'd11;
    endcase
  end
  always_ff @(posedge clk) begin
    rq <= (raddr == 5'd0) ? 32'd0 : rf[raddr];
    if (state == rvx_pkg::S_CLEAR) rf[clr[4:0]] <= 32'd0;
    else if (wr_en && rd != 5'd0) rf[rd] <= res;
  end

  // data memory, one byte port
  logic [Aw-1:0] maddr;
  logic          mwe;
  logic [7:0]    mwd;
  always_comb begin
    maddr = addr[Aw-1:0] + Aw'(bcnt);
    mwe = 1'b0;
    mwd = 8'd0;
    if (state == rvx_pkg::S_CLEAR) begin
      maddr = clr[Aw-1:0];
      mwe = 1'b1;
    end else if (state == rvx_pkg::S_STORE) begin
      mwe = 1'b1;
      mwd = 8'(b >> {bcnt, 3'b000});
    end
  end
  always_ff @(posedge clk) begin
    if (mwe) dmem[maddr] <= mwd;
    mem_q <= dmem[maddr];
  end

  // alu result for the ops not sent to the multiplier or divider, sets illegal
  logic [31:0] alu;
  logic        ill;
  logic [31:0] opb;
  logic [4:0]  sh;
  always_comb begin
    opb = (op == rvx_pkg::OP_R) ? b : imm_i;
    sh = opb[4:0];
    alu = 32'd0;
    ill = 1'b0;
    if (op == rvx_pkg::OP_R) begin
      if (f7 == 7'd0) begin
        unique case (f3)
          3'd0: alu = a + b;
          3'd1: alu = a << sh;
          3'd2: alu = {31'd0, $signed(a) < $signed(b)};
          3'd4: alu = a ^ b;
          3'd5: alu = a >> sh;
          3'd6: alu = a | b;
          3'd7: alu = a & b;
          default: ill = 1'b1;
        endcase
      end else if (f7 == rvx_pkg::F7_ALT) begin
        if (f3 == 3'd0) alu = a - b;
        else if (f3 == 3'd5) alu = 32'($signed(a) >>> sh);
        else ill = 1'b1;
      end else if (f7 == rvx_pkg::F7_MUL) begin
        ill = !(f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd4 || f3 == 3'd6);
      end else ill = 1'b1;
    end else begin
      unique case (f3)
        3'd0: alu = a + imm_i;
        3'd1: begin alu = a << sh; ill = (f7 != 7'd0); end
        3'd2: alu = {31'd0, $signed(a) < $signed(imm_i)};
        3'd4: alu = a ^ imm_i;
        3'd5: begin
          if (f7 == 7'd0) alu = a >> sh;
          else if (f7 == rvx_pkg::F7_ALT) alu = 32'($signed(a) >>> sh);
          else ill = 1'b1;
        end
        3'd6: alu = a | imm_i;
        3'd7: alu = a & imm_i;
        default: ill = 1'b1;
      endcase
    end
  end

  // signed 32 by 32 product for mul and mulh
  assign mprod = $signed(a) * $signed(b);

  // restoring divider step on magnitudes
  logic [32:0] dtrial;
  assign dtrial = {rem_r, quo[31]} - {1'b0, dvs};

  logic div_op, mul_op;
  assign mul_op = op == rvx_pkg::OP_R && f7 == rvx_pkg::F7_MUL && !f3[2];
  assign div_op = op == rvx_pkg::OP_R && f7 == rvx_pkg::F7_MUL && f3[2];

  always_comb begin
    state_next = state;
    unique case (state)
      rvx_pkg::S_CLEAR: if (clr == (Aw+1)'(rvx_pkg::MemoryBytes - 1)) state_next = rvx_pkg::S_IDLE;
      rvx_pkg::S_IDLE: if (s_axis_tvalid) state_next = rvx_pkg::S_REG;
      rvx_pkg::S_REG: if (rcnt == 2'd3) state_next = rvx_pkg::S_EXEC;
      rvx_pkg::S_EXEC: begin
        if (halted) state_next = rvx_pkg::S_OUT;
        else if (op == rvx_pkg::OP_R && !ill && div_op) state_next = rvx_pkg::S_DIV;
        else if (op == rvx_pkg::OP_R && !ill && mul_op) state_next = rvx_pkg::S_MUL;
        else if ((op == rvx_pkg::OP_LOAD || op == rvx_pkg::OP_STORE) && f3 <= 3'd2)
          state_next = rvx_pkg::S_MEM;
        else state_next = rvx_pkg::S_OUT;
      end
      rvx_pkg::S_DIV: if (dcnt == 6'd32) state_next = rvx_pkg::S_OUT;
      rvx_pkg::S_MUL: state_next = rvx_pkg::S_OUT;
      rvx_pkg::S_MEM: begin
        if (mend > 33'(rvx_pkg::MemoryBytes)) state_next = rvx_pkg::S_OUT;
        else if (op == rvx_pkg::OP_LOAD) state_next = rvx_pkg::S_LOAD;
        else state_next = rvx_pkg::S_STORE;
      end
      // a word waits for rcnt to wrap, its last byte arrives then
      rvx_pkg::S_LOAD: if ((msize != 2'd2 && rcnt == msize + 2'd1) ||
                           (msize == 2'd2 && rcnt == 2'd0 && bcnt == 2'd3))
        state_next = rvx_pkg::S_OUT;
      rvx_pkg::S_STORE: if (bcnt == ((2'd1 << msize) - 2'd1)) state_next = rvx_pkg::S_OUT;
      rvx_pkg::S_OUT: if (m_axis_tready) state_next = rvx_pkg::S_IDLE;
      default: state_next = rvx_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == rvx_pkg::S_IDLE;
    m_axis_tvalid = state == rvx_pkg::S_OUT;
    // halting statuses report the unchanged pc
    m_axis_tdata = {5'd0, pv, st, (st >= rvx_pkg::ST_EXIT) ? pc : npc};
  end

  logic [31:0] ma, mb, qv, rv;
  assign ma = a[31] ? -a : a;
  assign mb = b[31] ? -b : b;
  assign qv = ((a[31] ^ b[31]) ? -quo : quo);
  assign rv = a[31] ? -rem_r : rem_r;

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state <= rvx_pkg::S_CLEAR;
      clr <= '0;
      halted <= 1'b0;
      pc <= 32'd0;
      rcnt <= 2'd0;
      bcnt <= 2'd0;
    end else begin
      state <= state_next;
      unique case (state)
        rvx_pkg::S_CLEAR: clr <= clr + 1'b1;
        rvx_pkg::S_IDLE: if (s_axis_tvalid) begin
          ins <= s_axis_tdata;
          rcnt <= 2'd0;
        end
        rvx_pkg::S_REG: begin
          rcnt <= rcnt + 2'd1;
          // rq is registered, so it holds the register addressed on the previous rcnt
          unique case (rcnt)
            2'd1: a <= rq;
            2'd2: b <= rq;
            2'd3: a10 <= rq;
            default: ;
          endcase
        end
        rvx_pkg::S_EXEC: begin
          npc <= pc + 32'd4;
          st <= rvx_pkg::ST_OK;
          pv <= 32'd0;
          bcnt <= 2'd0;
          rcnt <= 2'd0;
          res <= 32'd0;
          addr <= a + ((op == rvx_pkg::OP_STORE) ? imm_s : imm_i);
          quo <= ma;
          rem_r <= 32'd0;
          dvs <= mb;
          dcnt <= 6'd0;
          if (halted) begin
            st <= rvx_pkg::ST_HALTED;
            npc <= pc;
          end else begin
            unique case (op)
              rvx_pkg::OP_R, rvx_pkg::OP_I: begin
                if (ill) st <= rvx_pkg::ST_ILLEGAL;
                else begin
                  res <= alu;
                  if (!(mul_op || div_op) || op == rvx_pkg::OP_I) wr_en <= 1'b1;
                end
              end
              rvx_pkg::OP_LOAD, rvx_pkg::OP_STORE:
                if (f3 > 3'd2) st <= rvx_pkg::ST_ILLEGAL;
              rvx_pkg::OP_BRANCH: begin
                if (f3 == 3'd0) begin if (a == b) npc <= pc + imm_b; end
                else if (f3 == 3'd1) begin if (a != b) npc <= pc + imm_b; end
                else st <= rvx_pkg::ST_ILLEGAL;
              end
              rvx_pkg::OP_LUI: begin res <= {ins[31:12], 12'd0}; wr_en <= 1'b1; end
              rvx_pkg::OP_JAL: begin
                res <= pc + 32'd4; wr_en <= 1'b1; npc <= pc + imm_j;
              end
              rvx_pkg::OP_ECALL: begin
                if (a10 == 32'd1) begin st <= rvx_pkg::ST_PRINT; pv <= rq; end
                else if (a10 == 32'd10) st <= rvx_pkg::ST_EXIT;
                else st <= rvx_pkg::ST_BAD_ECALL;
              end
              default: st <= rvx_pkg::ST_ILLEGAL;
            endcase
          end
        end
        rvx_pkg::S_MUL: begin
          res <= f3[0] ? mprod[63:32] : mprod[31:0];
        end
        rvx_pkg::S_DIV: begin
          if (dcnt != 6'd32) begin
            dcnt <= dcnt + 6'd1;
            if (!dtrial[32]) begin
              rem_r <= dtrial[31:0];
              quo <= {quo[30:0], 1'b1};
            end else begin
              rem_r <= {rem_r[30:0], quo[31]};
              quo <= {quo[30:0], 1'b0};
            end
          end
        end
        rvx_pkg::S_MEM: begin
          if (mend > 33'(rvx_pkg::MemoryBytes)) st <= rvx_pkg::ST_BAD_MEM;
          res <= 32'd0;
          bcnt <= 2'd0;
          rcnt <= 2'd0;
        end
        rvx_pkg::S_LOAD: begin
          // rcnt counts reads issued; mem_q is registered, so each byte arrives on the next rcnt
          if (rcnt != 2'd0) res <= res | (32'(mem_q) << {rcnt - 2'd1, 3'b000});
          if (bcnt != ((2'd1 << msize) - 2'd1)) bcnt <= bcnt + 2'd1;
          rcnt <= rcnt + 2'd1;
        end
        rvx_pkg::S_STORE: bcnt <= bcnt + 2'd1;
        rvx_pkg::S_OUT: ;
        default: ;
      endcase

      // finishing writes as the unit enters the result state
      if (state_next == rvx_pkg::S_OUT && state != rvx_pkg::S_OUT) begin
        if (state == rvx_pkg::S_MUL) begin
          wr_en <= 1'b1;
        end else if (state == rvx_pkg::S_DIV) begin
          wr_en <= 1'b1;
          if (b == 32'd0) res <= f3[1] ? a : 32'hffff_ffff;
          else if (a == 32'h8000_0000 && b == 32'hffff_ffff)
            res <= f3[1] ? 32'd0 : 32'h8000_0000;
          else res <= f3[1] ? rv : qv;
        end else if (state == rvx_pkg::S_LOAD) begin
          wr_en <= 1'b1;
          unique case (msize)
            2'd0: res <= {{24{mem_q[7]}}, mem_q};
            2'd1: res <= {{16{mem_q[7]}}, mem_q, res[7:0]};
            default: res <= {mem_q, res[23:0]};
          endcase
        end
      end
      if (state == rvx_pkg::S_OUT && m_axis_tready && st != rvx_pkg::ST_HALTED) begin
        if (st >= rvx_pkg::ST_EXIT) begin
          halted <= 1'b1;
          npc <= pc;
        end else pc <= npc;
      end
    end
  end
endmodule

// ===== hw/rtl/rvx_checker.sv =====
// port-level checks for the rv32 subset execute unit
// depends on the macros header and rvx_pkg
`timescale 1ns / 1ps
`include "rv32_subset_execute_unit_macros.svh"
module rvx_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  `RV_ASSERT_IMP(a_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `RV_ASSERT_NEVER(a_excl, clk, rst, s_axis_tready && m_axis_tvalid)
  `RV_ASSERT_IMP(a_status, clk, rst,
    m_axis_tvalid |-> m_axis_tdata[34:32] <= rvx_pkg::ST_HALTED)
  `RV_ASSERT_IMP(a_nopv, clk, rst,
    m_axis_tvalid && m_axis_tdata[34:32] != rvx_pkg::ST_PRINT |-> m_axis_tdata[66:35] == 32'd0)
endmodule
bind rv32_subset_execute_unit rvx_checker u_rvx_checker (.*);

// ===== dv/rv32_subset_execute_unit_tb.sv =====
// self-checking testbench for rv32_subset_execute_unit: directed and random instruction streams
// depends on rvx_pkg and the rv32_subset_execute_unit rtl
`timescale 1ns / 1ps
module rv32_subset_execute_unit_tb;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_DIV = 3'd4, F3_REM = 3'd6;
  localparam logic [2:0] F3_BYTE = 3'd0, F3_HALF = 3'd1, F3_WORD = 3'd2;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct packed {
    logic [31:0] npc;
    logic [2:0]  st;
    logic [31:0] pv;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0] regs[32];
    logic [31:0] pc;
    logic [7:0]  mem[rvx_pkg::MemoryBytes];
    bit          halted;
    exec_result_t pending[$];
    int errors, checked, prints;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
      halted = 0;
      errors = 0;
      checked = 0;
      prints = 0;
    endfunction

    function logic [31:0] mag(logic [31:0] x);
      return x[31] ? -x : x;
    endfunction

    function logic [31:0] quot(logic [31:0] a, logic [31:0] b);
      logic [31:0] q;
      if (b == 0) return '1;
      if (a == 32'h8000_0000 && b == '1) return a;
      q = mag(a) / mag(b);
      return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function logic [31:0] remainder(logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      if (b == 0) return a;
      if (a == 32'h8000_0000 && b == '1) return '0;
      r = mag(a) % mag(b);
      return a[31] ? -r : r;
    endfunction

    function bit fits(logic [31:0] addr, int size);
      return (64'(addr) + 64'(size)) <= 64'(rvx_pkg::MemoryBytes);
    endfunction

    function void write_reg(logic [4:0] idx, logic [31:0] v);
      if (idx != 0) regs[idx] = v;
    endfunction

    function exec_result_t execute(logic [31:0] ins);
      exec_result_t r;
      logic [6:0] op, f7;
      logic [4:0] rd;
      logic [2:0] f3;
      logic [31:0] a, b, v, addr, imm_i, imm_s, imm_b, imm_j;
      longint sa, sb, prod;
      int size;
      op = ins[6:0];
      rd = ins[11:7];
      f3 = ins[14:12];
      f7 = ins[31:25];
      a = regs[ins[19:15]];
      b = regs[ins[24:20]];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      r.npc = pc + 4;
      r.st = rvx_pkg::ST_OK;
      r.pv = '0;
      v = '0;
      if (halted) begin
        r.st = rvx_pkg::ST_HALTED;
        r.npc = pc;
        return r;
      end
      case (op)
        rvx_pkg::OP_R: begin
          sa = $signed(a);
          sb = $signed(b);
          prod = sa * sb;
          case ({f7, f3})
            {F7_BASE, F3_ADD}: v = a + b;
            {rvx_pkg::F7_ALT, F3_ADD}:  v = a - b;
            {rvx_pkg::F7_MUL, F3_MUL}:  v = a * b;
            {rvx_pkg::F7_MUL, F3_MULH}: v = prod[63:32];
            {rvx_pkg::F7_MUL, F3_DIV}:  v = quot(a, b);
            {rvx_pkg::F7_MUL, F3_REM}:  v = remainder(a, b);
            {F7_BASE, F3_SLL}: v = a << b[4:0];
            {F7_BASE, F3_SLT}: v = ($signed(a) < $signed(b)) ? 1 : 0;
            {F7_BASE, F3_XOR}: v = a ^ b;
            {F7_BASE, F3_SR}:  v = a >> b[4:0];
            {rvx_pkg::F7_ALT, F3_SR}:   v = $signed(a) >>> b[4:0];
            {F7_BASE, F3_OR}:  v = a | b;
            {F7_BASE, F3_AND}: v = a & b;
            default: r.st = rvx_pkg::ST_ILLEGAL;
          endcase
          if (r.st == rvx_pkg::ST_OK) write_reg(rd, v);
        end
        rvx_pkg::OP_I: begin
          case (f3)
            F3_ADD: v = a + imm_i;
            F3_SLL: if (f7 == F7_BASE) v = a << ins[24:20]; else r.st = rvx_pkg::ST_ILLEGAL;
            F3_SLT: v = ($signed(a) < $signed(imm_i)) ? 1 : 0;
            F3_XOR: v = a ^ imm_i;
            F3_SR: begin
              if (f7 == F7_BASE) v = a >> ins[24:20];
              else if (f7 == rvx_pkg::F7_ALT) v = $signed(a) >>> ins[24:20];
              else r.st = rvx_pkg::ST_ILLEGAL;
            end
            F3_OR:  v = a | imm_i;
            F3_AND: v = a & imm_i;
            default: r.st = rvx_pkg::ST_ILLEGAL;
          endcase
          if (r.st == rvx_pkg::ST_OK) write_reg(rd, v);
        end
        rvx_pkg::OP_LOAD: begin
          size = 1 << f3;
          addr = a + imm_i;
          if (f3 > F3_WORD) r.st = rvx_pkg::ST_ILLEGAL;
          else if (!fits(addr, size)) r.st = rvx_pkg::ST_BAD_MEM;
          else begin
            for (int i = 0; i < size; i++) v[8*i +: 8] = mem[addr + i];
            if (f3 == F3_BYTE) v = {{24{v[7]}}, v[7:0]};
            if (f3 == F3_HALF) v = {{16{v[15]}}, v[15:0]};
            write_reg(rd, v);
          end
        end
        rvx_pkg::OP_STORE: begin
          size = 1 << f3;
          addr = a + imm_s;
          if (f3 > F3_WORD) r.st = rvx_pkg::ST_ILLEGAL;
          else if (!fits(addr, size)) r.st = rvx_pkg::ST_BAD_MEM;
          else for (int i = 0; i < size; i++) mem[addr + i] = b[8*i +: 8];
        end
        rvx_pkg::OP_BRANCH: begin
          if (f3 == F3_BEQ) begin
            if (a == b) r.npc = pc + imm_b;
          end else if (f3 == F3_BNE) begin
            if (a != b) r.npc = pc + imm_b;
          end else r.st = rvx_pkg::ST_ILLEGAL;
        end
        rvx_pkg::OP_LUI: write_reg(rd, {ins[31:12], 12'h000});
        rvx_pkg::OP_JAL: begin
          write_reg(rd, pc + 4);
          r.npc = pc + imm_j;
        end
        rvx_pkg::OP_ECALL: begin
          if (regs[10] == 1) begin
            r.st = rvx_pkg::ST_PRINT;
            r.pv = regs[11];
          end else if (regs[10] == 10) r.st = rvx_pkg::ST_EXIT;
          else r.st = rvx_pkg::ST_BAD_ECALL;
        end
        default: r.st = rvx_pkg::ST_ILLEGAL;
      endcase
      if (r.st >= rvx_pkg::ST_EXIT) begin
        halted = 1;
        r.npc = pc;
      end
      pc = r.npc;
      return r;
    endfunction

    function void note_instr(logic [31:0] ins);
      pending.push_back(execute(ins));
    endfunction

    function void check_result(logic [71:0] d);
      exec_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.st == rvx_pkg::ST_PRINT) prints++;
      if (d[31:0] !== e.npc) begin
        $display("%0t: next_pc expected %h actual %h", $time, e.npc, d[31:0]);
        errors++;
      end
      if (d[34:32] !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, d[34:32]);
        errors++;
      end
      if (d[66:35] !== e.pv) begin
        $display("%0t: print_value expected %h actual %h", $time, e.pv, d[66:35]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // instruction
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;       // next_pc, status, print_value, zero fill

  exec_scoreboard sb = new();
  bit sending_done = 0;
  int halt_kind;

  rv32_subset_execute_unit dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvx_pkg::OP_R};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rvx_pkg::OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] off, logic [4:0] rd);
    return {off[20], off[10:1], off[11], off[19:12], rd, rvx_pkg::OP_JAL};
  endfunction

  // memory access that stays in range, falling back to an x0 base
  function automatic logic [31:0] mem_access(bit is_store);
    logic [4:0] rs1, rd;
    logic [11:0] imm;
    logic [2:0] f3;
    int size;
    rs1 = 5'($urandom);
    rd = 5'($urandom);
    imm = 12'($urandom);
    f3 = 3'($urandom_range(0, 2));
    size = 1 << f3;
    if (!sb.fits(sb.regs[rs1] + {{20{imm[11]}}, imm}, size)) begin
      rs1 = 0;
      imm = 12'($urandom_range(0, 2047));
    end
    if (is_store) return enc_s(imm, rd, rs1, f3);
    return enc_i(imm, rs1, f3, rd, rvx_pkg::OP_LOAD);
  endfunction

  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    logic [4:0] rs1, rs2, rd;
    int pick;
    w = $urandom;
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    rd = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 12))
        0: return enc_r(F7_BASE, rs2, rs1, F3_ADD, rd);
        1: return enc_r(rvx_pkg::F7_ALT, rs2, rs1, F3_ADD, rd);
        2: return enc_r(rvx_pkg::F7_MUL, rs2, rs1, F3_MUL, rd);
        3: return enc_r(rvx_pkg::F7_MUL, rs2, rs1, F3_MULH, rd);
        4: return enc_r(rvx_pkg::F7_MUL, rs2, rs1, F3_DIV, rd);
        5: return enc_r(rvx_pkg::F7_MUL, rs2, rs1, F3_REM, rd);
        6: return enc_r(F7_BASE, rs2, rs1, F3_SLL, rd);
        7: return enc_r(F7_BASE, rs2, rs1, F3_SLT, rd);
        8: return enc_r(F7_BASE, rs2, rs1, F3_XOR, rd);
        9: return enc_r(F7_BASE, rs2, rs1, F3_SR, rd);
        10: return enc_r(rvx_pkg::F7_ALT, rs2, rs1, F3_SR, rd);
        11: return enc_r(F7_BASE, rs2, rs1, F3_OR, rd);
        default: return enc_r(F7_BASE, rs2, rs1, F3_AND, rd);
      endcase
    end else if (pick < 55) begin
      case ($urandom_range(0, 7))
        0: return enc_i({F7_BASE, w[4:0]}, rs1, F3_SLL, rd, rvx_pkg::OP_I);
        1: return enc_i({F7_BASE, w[4:0]}, rs1, F3_SR, rd, rvx_pkg::OP_I);
        2: return enc_i({rvx_pkg::F7_ALT, w[4:0]}, rs1, F3_SR, rd, rvx_pkg::OP_I);
        3: return enc_i(w[11:0], rs1, F3_SLT, rd, rvx_pkg::OP_I);
        4: return enc_i(w[11:0], rs1, F3_XOR, rd, rvx_pkg::OP_I);
        5: return enc_i(w[11:0], rs1, F3_OR, rd, rvx_pkg::OP_I);
        6: return enc_i(w[11:0], rs1, F3_AND, rd, rvx_pkg::OP_I);
        default: return enc_i(w[11:0], rs1, F3_ADD, rd, rvx_pkg::OP_I);
      endcase
    end else if (pick < 65) return mem_access(0);
    else if (pick < 75) return mem_access(1);
    else if (pick < 83) begin
      if (w[20]) rs2 = rs1;  // make taken beq more likely
      return enc_b(w[12:0], rs2, rs1, w[13] ? F3_BNE : F3_BEQ);
    end else if (pick < 89) begin
      // small upper values give usable memory bases
      if (w[31]) return {16'h0000, w[15:12], rd, rvx_pkg::OP_LUI};
      return {w[31:12], rd, rvx_pkg::OP_LUI};
    end else if (pick < 93) return enc_j(w[20:0], rd);
    else if (sb.regs[10] == 1) return {w[31:7], rvx_pkg::OP_ECALL};
    return enc_i(12'd1, 5'd0, F3_ADD, 5'd10, rvx_pkg::OP_I);
  endfunction

  task automatic send_instr(logic [31:0] w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= w;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_instr(w);
  endtask

  initial begin
    logic [31:0] w;
    repeat (12) @(posedge clk);
    rst <= 0;
    // operand extremes
    send_instr(enc_i(12'h800, 5'd0, F3_ADD, 5'd1, rvx_pkg::OP_I));
    send_instr(enc_i(12'h7ff, 5'd0, F3_ADD, 5'd2, rvx_pkg::OP_I));
    send_instr({20'h80000, 5'd4, rvx_pkg::OP_LUI});
    send_instr(enc_i(12'hfff, 5'd0, F3_ADD, 5'd5, rvx_pkg::OP_I));
    // most negative over minus one, and divide by zero
    send_instr(enc_r(rvx_pkg::F7_MUL, 5'd5, 5'd4, F3_DIV, 5'd8));
    send_instr(enc_r(rvx_pkg::F7_MUL, 5'd5, 5'd4, F3_REM, 5'd9));
    send_instr(enc_r(rvx_pkg::F7_MUL, 5'd0, 5'd1, F3_DIV, 5'd12));
    send_instr(enc_r(rvx_pkg::F7_MUL, 5'd0, 5'd1, F3_REM, 5'd13));
    send_instr(enc_r(rvx_pkg::F7_MUL, 5'd4, 5'd4, F3_MULH, 5'd14));
    send_instr(enc_r(rvx_pkg::F7_ALT, 5'd5, 5'd4, F3_SR, 5'd15));
    send_instr(enc_i({rvx_pkg::F7_ALT, 5'd31}, 5'd4, F3_SR, 5'd16, rvx_pkg::OP_I));
    send_instr(enc_i({F7_BASE, 5'd31}, 5'd5, F3_SLL, 5'd17, rvx_pkg::OP_I));
    send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd18));
    // top of the data store, misaligned
    send_instr({20'h00010, 5'd6, rvx_pkg::OP_LUI});
    send_instr(enc_s(12'hffc, 5'd4, 5'd6, F3_WORD));
    send_instr(enc_i(12'hffd, 5'd6, F3_HALF, 5'd19, rvx_pkg::OP_LOAD));
    send_instr(enc_i(12'hfff, 5'd6, F3_BYTE, 5'd20, rvx_pkg::OP_LOAD));
    send_instr(enc_i(12'hffc, 5'd6, F3_WORD, 5'd0, rvx_pkg::OP_LOAD));
    send_instr(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));
    send_instr(enc_b(13'h0ffe, 5'd2, 5'd1, F3_BNE));
    send_instr(enc_j(21'h100000, 5'd21));
    send_instr(enc_i(12'd1, 5'd0, F3_ADD, 5'd10, rvx_pkg::OP_I));
    send_instr({25'h1ffffff, rvx_pkg::OP_ECALL});
    repeat (RANDOM_ITEMS) send_instr(random_instr());
    // one halting case ends the program, then later beats must report halted
    halt_kind = $urandom_range(0, 3);
    case (halt_kind)
      0: begin
        send_instr(enc_i(12'd10, 5'd0, F3_ADD, 5'd10, rvx_pkg::OP_I));
        w = $urandom;
        send_instr({w[31:7], rvx_pkg::OP_ECALL});
      end
      1: begin
        w = $urandom;
        send_instr({w[31:2], 2'b00});
      end
      2: begin
        send_instr(enc_i(12'd7, 5'd0, F3_ADD, 5'd10, rvx_pkg::OP_I));
        send_instr({25'h0, rvx_pkg::OP_ECALL});
      end
      default: begin
        send_instr({20'h00010, 5'd7, rvx_pkg::OP_LUI});
        send_instr(enc_i(12'hffe, 5'd7, F3_WORD, 5'd8, rvx_pkg::OP_LOAD));
      end
    endcase
    repeat (12) send_instr($urandom);
    s_axis_tvalid <= 0;
    sending_done = 1;
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("checked %0d results, %0d prints; program ended by halting case %0d",
             sb.checked, sb.prints, halt_kind);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== rv32_subset_execute_unit.f =====
+incdir+hw/rtl
hw/rtl/rvx_pkg.sv
hw/rtl/rv32_subset_execute_unit.sv
hw/rtl/rvx_checker.sv
dv/rv32_subset_execute_unit_tb.sv
